>>> design/sdc_pkg.sv
// Shared constants, tables and types for the serial day to calendar date block.
// Depends on nothing; every other design file refers to it by scoped names.

package sdc_pkg;

  // Calendar span and field widths
  localparam int BASE_YEAR  = 1900;
  localparam int YEAR_COUNT = 256;
  localparam int SERIAL_W   = 17;
  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int MONTHS     = 12;
  localparam int YTD_W      = 9;

  // Cumulative day counts and search widths
  localparam int START_W = $clog2(YEAR_COUNT * 366 + 1);
  localparam int SUB_W   = (START_W > SERIAL_W) ? START_W : SERIAL_W;
  localparam int YB      = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1;
  localparam int TIDX_W  = $clog2(YEAR_COUNT + 1);

  localparam logic [YEAR_W-1:0] BASE_YEAR_LO = YEAR_W'(BASE_YEAR);

  typedef logic [START_W-1:0] start_t;
  typedef start_t             start_tab_t [0:YEAR_COUNT];
  typedef logic [YTD_W-1:0]   ytd_t;

  // Gregorian 4/100/400 rule
  function automatic logic is_leap(input int y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  // Day number of 1 January for each supported year, plus the end bound
  function automatic start_tab_t build_year_starts();
    start_tab_t t;
    int         acc;
    acc = 0;
    for (int k = 0; k <= YEAR_COUNT; k++) begin
      t[k] = START_W'(acc);
      acc  = acc + (is_leap(BASE_YEAR + k) ? 366 : 365);
    end
    return t;
  endfunction

  function automatic logic [YEAR_COUNT-1:0] build_leap_mask();
    logic [YEAR_COUNT-1:0] m;
    m = '0;
    for (int k = 0; k < YEAR_COUNT; k++) begin
      m[k] = is_leap(BASE_YEAR + k);
    end
    return m;
  endfunction

  localparam start_tab_t            YEAR_START = build_year_starts();
  localparam logic [YEAR_COUNT-1:0] LEAP_MASK  = build_leap_mask();

  // First day of each month in a common year
  localparam ytd_t MONTH_START [MONTHS] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Operands into the shared subtract and compare unit
  typedef struct packed {
    logic [SUB_W-1:0] a;
    logic [SUB_W-1:0] b;
  } sub_req_t;

  // Difference and a-not-below-b flag out of the unit
  typedef struct packed {
    logic [SUB_W-1:0] diff;
    logic             ge;
  } sub_rsp_t;

  // One finished result word
  typedef struct packed {
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;
    logic               leap_flag;
    logic               out_of_range;
  } result_t;

endpackage

>>> design/sdc_sub_unit.sv
// Shared subtract and compare unit used by every step of the date search.
// Depends on sdc_pkg for operand widths and the request and response structs.

module sdc_sub_unit (
  input  sdc_pkg::sub_req_t req,
  output sdc_pkg::sub_rsp_t rsp
);

  logic [sdc_pkg::SUB_W:0] wide;

  // Subtract with one extra bit; a clear borrow means a >= b
  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = wide[sdc_pkg::SUB_W-1:0];
  assign rsp.ge   = ~wide[sdc_pkg::SUB_W];

endmodule

>>> design/sdc_seq.sv
// Sequencer: range check, bitwise search over year starts, day of year, month search, day.
// Depends on sdc_pkg; drives the shared unit in sdc_sub_unit through a struct.

module sdc_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sdc_pkg::SERIAL_W-1:0]  serial,
  input  logic                          out_free,
  output logic                          idle,
  output sdc_pkg::sub_req_t             sub_req,
  input  sdc_pkg::sub_rsp_t             sub_rsp,
  output logic                          res_load,
  output sdc_pkg::result_t              res
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RANGE = 6'b000010,
    ST_YSRCH = 6'b000100,
    ST_YTD   = 6'b001000,
    ST_MSRCH = 6'b010000,
    ST_DAY   = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [sdc_pkg::SERIAL_W-1:0]   serial_r;
  logic [sdc_pkg::YB-1:0]         ylo_r, ylo_nxt, ymask_r, ymask_nxt;
  sdc_pkg::ytd_t                  ytd_r, ytd_nxt;
  logic [sdc_pkg::MONTH_W-1:0]    mlo_r, mlo_nxt, mmask_r, mmask_nxt;

  logic [sdc_pkg::YB-1:0]         ycand;
  logic                           ycand_ok;
  logic [sdc_pkg::MONTH_W-1:0]    mcand, midx;
  logic                           mcand_ok;
  logic [sdc_pkg::TIDX_W-1:0]     tidx;
  logic                           leap;
  sdc_pkg::ytd_t                  mstart_adj;
  logic                           year_phase;

  assign idle = (state_r == ST_IDLE);

  // Candidates: set the next lower bit of the current lower bound
  assign ycand    = ylo_r | ymask_r;
  assign ycand_ok = (32'(ycand) < 32'(sdc_pkg::YEAR_COUNT));
  assign mcand    = mlo_r | mmask_r;
  assign mcand_ok = (mcand < sdc_pkg::MONTH_W'(sdc_pkg::MONTHS));
  assign leap     = sdc_pkg::LEAP_MASK[ylo_r];

  // Year start table address
  always_comb begin
    if (state_r == ST_RANGE) begin
      tidx = sdc_pkg::TIDX_W'(sdc_pkg::YEAR_COUNT);
    end else if ((state_r == ST_YSRCH) && ycand_ok) begin
      tidx = sdc_pkg::TIDX_W'(ycand);
    end else begin
      tidx = sdc_pkg::TIDX_W'(ylo_r);
    end
  end

  // Month start, one day later after February in a leap year
  assign midx = ((state_r == ST_MSRCH) && mcand_ok) ? mcand : mlo_r;
  assign mstart_adj = sdc_pkg::MONTH_START[midx]
                    + sdc_pkg::ytd_t'(leap && (midx >= sdc_pkg::MONTH_W'(2)));

  // Steer the shared unit
  assign year_phase = (state_r == ST_RANGE) || (state_r == ST_YSRCH) ||
                      (state_r == ST_YTD);
  always_comb begin
    if (year_phase) begin
      sub_req.a = sdc_pkg::SUB_W'(serial_r);
      sub_req.b = sdc_pkg::SUB_W'(sdc_pkg::YEAR_START[tidx]);
    end else begin
      sub_req.a = sdc_pkg::SUB_W'(ytd_r);
      sub_req.b = sdc_pkg::SUB_W'(mstart_adj);
    end
  end

  // Next state and search registers
  always_comb begin
    state_nxt = state_r;
    ylo_nxt   = ylo_r;
    ymask_nxt = ymask_r;
    ytd_nxt   = ytd_r;
    mlo_nxt   = mlo_r;
    mmask_nxt = mmask_r;
    res_load  = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        ylo_nxt   = '0;
        ymask_nxt = {1'b1, {(sdc_pkg::YB-1){1'b0}}};
        if (!sub_rsp.ge) begin
          state_nxt = ST_YSRCH;
        end else if (out_free) begin
          // past the last year: date fields and leap flag zero, out_of_range set
          res_load         = 1'b1;
          res.out_of_range = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_YSRCH: begin
        if (ycand_ok && sub_rsp.ge) begin
          ylo_nxt = ycand;
        end
        ymask_nxt = ymask_r >> 1;
        if (ymask_r[0]) begin
          state_nxt = ST_YTD;
        end
      end
      ST_YTD: begin
        ytd_nxt   = sub_rsp.diff[sdc_pkg::YTD_W-1:0];
        mlo_nxt   = '0;
        mmask_nxt = {1'b1, {(sdc_pkg::MONTH_W-1){1'b0}}};
        state_nxt = ST_MSRCH;
      end
      ST_MSRCH: begin
        if (mcand_ok && sub_rsp.ge) begin
          mlo_nxt = mcand;
        end
        mmask_nxt = mmask_r >> 1;
        if (mmask_r[0]) begin
          state_nxt = ST_DAY;
        end
      end
      ST_DAY: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.cal_year  = sdc_pkg::BASE_YEAR_LO + sdc_pkg::YEAR_W'(ylo_r);
          res.cal_month = mlo_r + sdc_pkg::MONTH_W'(1);
          res.cal_day   = sub_rsp.diff[sdc_pkg::DAY_W-1:0] + sdc_pkg::DAY_W'(1);
          res.leap_flag = leap;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk) begin
    if (start && idle) begin
      serial_r <= serial;
    end
    ylo_r   <= ylo_nxt;
    ymask_r <= ymask_nxt;
    ytd_r   <= ytd_nxt;
    mlo_r   <= mlo_nxt;
    mmask_r <= mmask_nxt;
  end

endmodule

>>> design/serial_day_to_calendar_date_top.sv
// Serial day number to Gregorian date. Steps per word for 256 years: range
// check, 8 year-search steps, 1 day-of-year step, 4 month-search steps, 1 day
// step; a word past the last year ends after the range check. One word in
// flight, and all steps share the single subtract/compare unit. The last step
// waits while the output register holds an untaken word. The output register
// lets the next word start. Synchronous active-low reset empties the output
// register and idles the FSM.

module serial_day_to_calendar_date_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdc_pkg::SERIAL_W-1:0]  in_day_serial,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdc_pkg::YEAR_W-1:0]    out_cal_year,
  output logic [sdc_pkg::MONTH_W-1:0]   out_cal_month,
  output logic [sdc_pkg::DAY_W-1:0]     out_cal_day,
  output logic                          out_leap_flag,
  output logic                          out_out_of_range
);

  sdc_pkg::sub_req_t sub_req;
  sdc_pkg::sub_rsp_t sub_rsp;
  sdc_pkg::result_t  res, out_r;
  logic              res_load, idle, out_free, out_valid_r;

  // Output slot frees when empty or being taken this cycle
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = idle;

  sdc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid),
    .serial   (in_day_serial),
    .out_free (out_free),
    .idle     (idle),
    .sub_req  (sub_req),
    .sub_rsp  (sub_rsp),
    .res_load (res_load),
    .res      (res)
  );

  sdc_sub_unit u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  // Output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cal_year     = out_r.cal_year;
  assign out_cal_month    = out_r.cal_month;
  assign out_cal_day      = out_r.cal_day;
  assign out_leap_flag    = out_r.leap_flag;
  assign out_out_of_range = out_r.out_of_range;

endmodule

>>> design/sdc_checker.sv
// Port-level checks for the serial day to calendar date block, bound to the top.
// Depends on sdc_pkg for field widths.

module sdc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sdc_pkg::YEAR_W-1:0]    out_cal_year,
  input logic [sdc_pkg::MONTH_W-1:0]   out_cal_month,
  input logic [sdc_pkg::DAY_W-1:0]     out_cal_day,
  input logic                          out_leap_flag,
  input logic                          out_out_of_range
);

  // Out-of-range word carries zero date fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_cal_year == '0 && out_cal_month == '0 && out_cal_day == '0 && !out_leap_flag)
    else $error("out-of-range word with nonzero date fields");

  // In-range word has a real month and day
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_cal_month >= 4'd1 && out_cal_month <= 4'd12 &&
      out_cal_day >= 5'd1 && out_cal_day <= 5'd31)
    else $error("month or day outside calendar range");

  // February in a common year ends on the 28th
  a_feb_common: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range && !out_leap_flag && out_cal_month == 4'd2 |->
      out_cal_day <= 5'd28)
    else $error("day 29 of February in a common year");

  // Search is busy the cycle after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a search is running");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_cal_year) && $stable(out_cal_month) &&
      $stable(out_cal_day) && $stable(out_leap_flag) && $stable(out_out_of_range))
    else $error("stalled result word changed");

endmodule

bind serial_day_to_calendar_date_top sdc_checker u_sdc_checker (.*);
